// ----- src/htq_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants and types for the heightfield height query core.
// No dependencies.
package htq_pkg;

   typedef enum logic {
      FUNC_WRITE = 1'b0,
      FUNC_QUERY = 1'b1
   } func_type;

   localparam int          CSR_IDX_W         = 2;
   localparam logic [1:0]  CSR_ORIGIN_X      = 2'd0;
   localparam logic [1:0]  CSR_ORIGIN_Z      = 2'd1;
   localparam logic [1:0]  CSR_INV_CELL_SIZE = 2'd2;
   localparam logic [1:0]  CSR_VERTS_SIDE    = 2'd3;

   localparam logic [31:0] INV_CELL_RESET    = 32'h0001_0000;
   localparam logic [8:0]  VERTS_RESET       = 9'd256;

   localparam logic [16:0] ONE_Q16           = 17'h1_0000;
   localparam logic signed [48:0] HALF_Q16   = 49'sd32768;

   // Result queue; also bounds the number of queries in flight past the issue stage.
   localparam int          RSP_DEPTH         = 4;
   localparam int          RSP_PTR_W         = 2;
   localparam int          RSP_CNT_W         = 3;

endpackage

// ----- src/heightfield_triangle_height_query_core.sv -----
`timescale 1ns / 1ps
// Heightfield height query core: height memory, coordinate mapping and barycentric blend.
// Depends on htq_pkg.
//
// Usage: write items (func 0) store one height at column*GRID_SIDE+row and are taken at one
// per cycle while no query ahead of them waits; query items (func 1) make three corner reads
// each, one per cycle through the single port of the height memory, and hold the issue stage
// until the last one. A query whose cell is outside the grid makes a single access only. All
// memory accesses happen in item order, so a query always sees every earlier write. A result
// passes stages 1 to 3, the issue, the memory read, the product and the accumulator; up to
// four results queue at the output while the response side stalls. The height memory is not
// initialized: query only cells whose corners have been written.
module heightfield_triangle_height_query_core
   import htq_pkg::*;
#(
   parameter int GRID_SIDE = 256
) (
   input  logic                  clock,
   input  logic                  reset,

   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [31:0]           csr_wdata,

   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic                  req_func,
   input  logic [7:0]            req_column,
   input  logic [7:0]            req_row,
   input  logic signed [31:0]    req_height_in,
   input  logic signed [31:0]    req_world_x,
   input  logic signed [31:0]    req_world_z,

   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic signed [31:0]    rsp_height_out,
   output logic                  rsp_in_range
);

   localparam int          CW     = $clog2(GRID_SIDE);
   localparam int          DEPTH  = GRID_SIDE * GRID_SIDE;
   localparam int          AW     = $clog2(DEPTH);
   localparam logic [AW-1:0] SIDE_A = AW'(GRID_SIDE);
   localparam logic [31:0] SIDE_W = 32'(GRID_SIDE);

   // ---------------- configuration ----------------
   logic signed [31:0] origin_x_ff, origin_z_ff;
   logic [31:0]        inv_cell_ff;
   logic [8:0]         verts_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_z_ff <= '0;
         inv_cell_ff <= INV_CELL_RESET;
         verts_ff    <= VERTS_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_ORIGIN_X:      origin_x_ff <= csr_wdata;
            CSR_ORIGIN_Z:      origin_z_ff <= csr_wdata;
            CSR_INV_CELL_SIZE: inv_cell_ff <= csr_wdata;
            CSR_VERTS_SIDE:    verts_ff    <= csr_wdata[8:0];
         endcase
      end
   end

   // ---------------- front pipeline control ----------------
   logic adv;
   logic s3_valid_ff, s3_take;

   assign adv       = !s3_valid_ff || s3_take;
   assign req_ready = adv;

   // ---------------- stage 1: offset magnitude ----------------
   logic              s1_valid_ff;
   func_type          s1_func_ff;
   logic              s1_wr_ok_ff;
   logic [CW-1:0]     s1_col_ff, s1_row_ff;
   logic signed [31:0] s1_hgt_ff;
   logic [31:0]       s1_mag_x_ff, s1_mag_z_ff;
   logic              s1_neg_x_ff, s1_neg_z_ff;

   logic signed [32:0] tx_pos, tx_neg, tz_pos, tz_neg;
   logic [31:0]        col_w, row_w;

   always_comb begin
      tx_pos = 33'(req_world_x) - 33'(origin_x_ff);
      tx_neg = 33'(origin_x_ff) - 33'(req_world_x);
      tz_pos = 33'(req_world_z) - 33'(origin_z_ff);
      tz_neg = 33'(origin_z_ff) - 33'(req_world_z);
      col_w  = 32'(req_column);
      row_w  = 32'(req_row);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_func_ff  <= func_type'(req_func);
         s1_wr_ok_ff <= (col_w < SIDE_W) && (row_w < SIDE_W);
         s1_col_ff   <= col_w[CW-1:0];
         s1_row_ff   <= row_w[CW-1:0];
         s1_hgt_ff   <= req_height_in;
         s1_neg_x_ff <= tx_pos[32];
         s1_neg_z_ff <= tz_pos[32];
         s1_mag_x_ff <= tx_pos[32] ? tx_neg[31:0] : tx_pos[31:0];
         s1_mag_z_ff <= tz_pos[32] ? tz_neg[31:0] : tz_pos[31:0];
      end
   end

   // ---------------- stage 2: scale by reciprocal cell size ----------------
   logic              s2_valid_ff;
   func_type          s2_func_ff;
   logic              s2_wr_ok_ff;
   logic [CW-1:0]     s2_col_ff, s2_row_ff;
   logic signed [31:0] s2_hgt_ff;
   logic [63:0]       s2_p_x_ff, s2_p_z_ff;
   logic              s2_neg_x_ff, s2_neg_z_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (adv) begin
         s2_valid_ff <= s1_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s2_func_ff  <= s1_func_ff;
         s2_wr_ok_ff <= s1_wr_ok_ff;
         s2_col_ff   <= s1_col_ff;
         s2_row_ff   <= s1_row_ff;
         s2_hgt_ff   <= s1_hgt_ff;
         s2_neg_x_ff <= s1_neg_x_ff;
         s2_neg_z_ff <= s1_neg_z_ff;
         s2_p_x_ff   <= 64'(s1_mag_x_ff) * 64'(inv_cell_ff);
         s2_p_z_ff   <= 64'(s1_mag_z_ff) * 64'(inv_cell_ff);
      end
   end

   // ---------------- stage 3: cell, range, triangle and weights ----------------
   func_type          s3_func_ff;
   logic              s3_wr_ok_ff;
   logic              s3_inr_ff;
   logic signed [31:0] s3_hgt_ff;
   logic [CW-1:0]     s3_col_ff [0:2];
   logic [CW-1:0]     s3_row_ff [0:2];
   logic [16:0]       s3_w_ff   [0:2];

   logic [31:0]   side_w;
   logic [15:0]   fx, fz;
   logic [16:0]   sumf;
   logic          upper, ok_x, ok_z, bad_x, bad_z, inr;
   logic [CW-1:0] cx, cz, cx1, cz1;
   logic [CW-1:0] col_in [0:2];
   logic [CW-1:0] row_in [0:2];
   logic [16:0]   w_in   [0:2];

   always_comb begin
      side_w = (32'(verts_ff) > SIDE_W) ? SIDE_W : 32'(verts_ff);
      fx     = s2_p_x_ff[31:16];
      fz     = s2_p_z_ff[31:16];
      sumf   = {1'b0, fx} + {1'b0, fz};
      upper  = sumf > ONE_Q16;
      bad_x  = s2_neg_x_ff && (s2_p_x_ff != '0);
      bad_z  = s2_neg_z_ff && (s2_p_z_ff != '0);
      ok_x   = ({1'b0, s2_p_x_ff[63:32]} + 33'd1) < {1'b0, side_w};
      ok_z   = ({1'b0, s2_p_z_ff[63:32]} + 33'd1) < {1'b0, side_w};
      inr    = !bad_x && !bad_z && ok_x && ok_z;
      cx     = s2_p_x_ff[32+CW-1:32];
      cz     = s2_p_z_ff[32+CW-1:32];
      cx1    = cx + 1'b1;
      cz1    = cz + 1'b1;
      if (upper) begin
         col_in[0] = cx1;  row_in[0] = cz;   w_in[0] = ONE_Q16 - {1'b0, fz};
         col_in[1] = cx1;  row_in[1] = cz1;  w_in[1] = sumf - ONE_Q16;
         col_in[2] = cx;   row_in[2] = cz1;  w_in[2] = ONE_Q16 - {1'b0, fx};
      end else begin
         col_in[0] = cx;   row_in[0] = cz;   w_in[0] = ONE_Q16 - sumf;
         col_in[1] = cx1;  row_in[1] = cz;   w_in[1] = {1'b0, fx};
         col_in[2] = cx;   row_in[2] = cz1;  w_in[2] = {1'b0, fz};
      end
      if (s2_func_ff == FUNC_WRITE) begin
         col_in[0] = s2_col_ff;
         row_in[0] = s2_row_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (adv) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s3_func_ff  <= s2_func_ff;
         s3_wr_ok_ff <= s2_wr_ok_ff;
         s3_inr_ff   <= inr;
         s3_hgt_ff   <= s2_hgt_ff;
         for (int i = 0; i < 3; i++) begin
            s3_col_ff[i] <= col_in[i];
            s3_row_ff[i] <= row_in[i];
            s3_w_ff[i]   <= w_in[i];
         end
      end
   end

   // ---------------- issue: one memory access per cycle unless stalled for result queue room ----------------
   logic [1:0]           phase_ff, phase_in;
   logic [RSP_CNT_W-1:0] out_cnt_ff;
   logic                 is_wr, credit_ok, go, start, last_tok, mem_we;
   logic [AW-1:0]        mem_addr;
   logic                 rsp_take;

   always_comb begin
      is_wr     = s3_func_ff == FUNC_WRITE;
      credit_ok = out_cnt_ff < RSP_CNT_W'(RSP_DEPTH);
      go        = s3_valid_ff && (is_wr || (phase_ff != 2'd0) || credit_ok);
      start     = go && !is_wr && (phase_ff == 2'd0);
      last_tok  = !s3_inr_ff || (phase_ff == 2'd2);
      s3_take   = go && (is_wr || last_tok);
      mem_we    = go && is_wr && s3_wr_ok_ff;
      mem_addr  = AW'(s3_col_ff[phase_ff]) * SIDE_A + AW'(s3_row_ff[phase_ff]);
      phase_in  = phase_ff;
      if (go && !is_wr && s3_inr_ff) begin
         phase_in = (phase_ff == 2'd2) ? 2'd0 : phase_ff + 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= 2'd0;
         out_cnt_ff <= '0;
      end else begin
         phase_ff   <= phase_in;
         out_cnt_ff <= out_cnt_ff + RSP_CNT_W'(start) - RSP_CNT_W'(rsp_take);
      end
   end

   // ---------------- height memory ----------------
   logic [31:0] height_mem [DEPTH];
   logic signed [31:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_we) begin
         height_mem[mem_addr] <= s3_hgt_ff;
      end
      rd_data_ff <= height_mem[mem_addr];
   end

   // ---------------- blend: multiply, accumulate, round ----------------
   logic        t1_valid_ff, t1_first_ff, t1_last_ff, t1_oor_ff;
   logic [16:0] t1_w_ff;
   logic        t2_valid_ff, t2_first_ff, t2_last_ff, t2_oor_ff;
   logic signed [48:0] prod_ff;
   logic        t3_done_ff, t3_oor_ff;
   logic signed [48:0] acc_ff;

   logic signed [17:0] w_s;
   logic signed [49:0] prod_full;
   logic signed [48:0] rnd;

   always_comb begin
      w_s       = signed'({1'b0, t1_w_ff});
      prod_full = rd_data_ff * w_s;
      rnd       = acc_ff + HALF_Q16;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_valid_ff <= 1'b0;
         t2_valid_ff <= 1'b0;
         t3_done_ff  <= 1'b0;
      end else begin
         t1_valid_ff <= go && !is_wr;
         t2_valid_ff <= t1_valid_ff;
         t3_done_ff  <= t2_valid_ff && t2_last_ff;
      end
   end

   always_ff @(posedge clock) begin
      t1_first_ff <= phase_ff == 2'd0;
      t1_last_ff  <= last_tok;
      t1_oor_ff   <= !s3_inr_ff;
      t1_w_ff     <= s3_w_ff[phase_ff];
      t2_first_ff <= t1_first_ff;
      t2_last_ff  <= t1_last_ff;
      t2_oor_ff   <= t1_oor_ff;
      prod_ff     <= t1_oor_ff ? '0 : prod_full[48:0];
      t3_oor_ff   <= t2_oor_ff;
      if (t2_valid_ff) begin
         acc_ff <= t2_first_ff ? prod_ff : acc_ff + prod_ff;
      end
   end

   // ---------------- result queue ----------------
   logic [32:0]          rsp_q [RSP_DEPTH];
   logic [RSP_PTR_W-1:0] wr_ptr_ff, rd_ptr_ff;
   logic [RSP_CNT_W-1:0] q_cnt_ff;
   logic [32:0]          rsp_head;

   assign rsp_valid      = q_cnt_ff != '0;
   assign rsp_take       = rsp_valid && rsp_ready;
   assign rsp_head       = rsp_q[rd_ptr_ff];
   assign rsp_height_out = rsp_head[31:0];
   assign rsp_in_range   = rsp_head[32];

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         q_cnt_ff  <= '0;
      end else begin
         if (t3_done_ff) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (rsp_take) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         q_cnt_ff <= q_cnt_ff + RSP_CNT_W'(t3_done_ff) - RSP_CNT_W'(rsp_take);
      end
   end

   always_ff @(posedge clock) begin
      if (t3_done_ff) begin
         rsp_q[wr_ptr_ff] <= t3_oor_ff ? 33'd0 : {1'b1, rnd[47:16]};
      end
   end

endmodule
